@@ design/tiny_mersenne_twister_32_assert.svh @@
// Assertion macros used by the generator's top level.
`ifndef TINY_MERSENNE_TWISTER_32_ASSERT_SVH
`define TINY_MERSENNE_TWISTER_32_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define TMT32_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define TMT32_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ design/tmt32_pkg.sv @@
// Types, constants, microprogram and datapath functions of the TinyMT32 generator.
`default_nettype none
package tmt32_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] state_t;

	localparam int ROUND_W = 4;
	typedef logic [ROUND_W-1:0] round_t;

	localparam word_t LOW31_MASK = 32'h7fff_ffff;
	localparam word_t MIX_MULT   = 32'd1812433253;
	localparam int    MIX_SHIFT  = 30;
	localparam int    SHIFT_A    = 1;
	localparam int    SHIFT_B    = 10;
	localparam int    SHIFT_T    = 8;

	localparam word_t MAT1_RESET = 32'h8f70_11ee;
	localparam word_t MAT2_RESET = 32'hfc78_ff1f;
	localparam word_t TMAT_RESET = 32'h3793_fdff;

	localparam word_t CHAR_T = 32'h0000_0054;
	localparam word_t CHAR_I = 32'h0000_0049;
	localparam word_t CHAR_N = 32'h0000_004e;
	localparam word_t CHAR_Y = 32'h0000_0059;

	typedef enum logic [1:0] {
		REG_MAT1 = 2'd0,
		REG_MAT2 = 2'd1,
		REG_TMAT = 2'd2
	} reg_idx_t;

	localparam logic OPER_SEED = 1'b0;
	localparam logic OPER_GEN  = 1'b1;

	typedef enum logic [2:0] {
		OP_NOP  = 3'd0,
		OP_LOAD = 3'd1,
		OP_MUL  = 3'd2,
		OP_MIX  = 3'd3,
		OP_CERT = 3'd4,
		OP_ADV  = 3'd5,
		OP_GEN  = 3'd6
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_DISPATCH  = 3'd2,
		C_NO_MIX    = 3'd3,
		C_MIX_MORE  = 3'd4,
		C_NO_WARM   = 3'd5,
		C_WARM_MORE = 3'd6
	} cond_t;

	typedef logic [2:0] step_t;

	localparam step_t S_DISPATCH = 3'd0;
	localparam step_t S_LOAD     = 3'd1;
	localparam step_t S_MUL      = 3'd2;
	localparam step_t S_MIX      = 3'd3;
	localparam step_t S_CERT     = 3'd4;
	localparam step_t S_WARM     = 3'd5;
	localparam step_t S_END      = 3'd6;
	localparam step_t S_GEN      = 3'd7;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		step_t  target;
		logic   hold_out;
	} uword_t;

	typedef struct packed {
		dp_op_t op;
		round_t round;
	} dp_ctrl_t;

	function automatic uword_t urom(input step_t step);
		uword_t u;
		u = '{op: OP_NOP, cond: C_ALWAYS, target: S_DISPATCH, hold_out: 1'b0};
		unique case (step)
			S_DISPATCH: u = '{op: OP_NOP,  cond: C_DISPATCH,  target: S_GEN,  hold_out: 1'b0};
			S_LOAD:     u = '{op: OP_LOAD, cond: C_NO_MIX,    target: S_CERT, hold_out: 1'b0};
			S_MUL:      u = '{op: OP_MUL,  cond: C_NEXT,      target: S_MIX,  hold_out: 1'b0};
			S_MIX:      u = '{op: OP_MIX,  cond: C_MIX_MORE,  target: S_MUL,  hold_out: 1'b0};
			S_CERT:     u = '{op: OP_CERT, cond: C_NO_WARM,   target: S_END,
			                  hold_out: 1'b0};
			S_WARM:     u = '{op: OP_ADV,  cond: C_WARM_MORE, target: S_WARM, hold_out: 1'b0};
			S_END:      u = '{op: OP_NOP,  cond: C_ALWAYS,    target: S_DISPATCH,
			                  hold_out: 1'b0};
			S_GEN:      u = '{op: OP_GEN,  cond: C_ALWAYS,    target: S_DISPATCH,
			                  hold_out: 1'b1};
			default:    u = '{op: OP_NOP,  cond: C_ALWAYS,    target: S_DISPATCH,
			                  hold_out: 1'b0};
		endcase
		return u;
	endfunction

	function automatic state_t advance(input state_t s, input word_t mat1, input word_t mat2);
		word_t  x;
		word_t  y;
		state_t n;
		x = (s[0] & LOW31_MASK) ^ s[1] ^ s[2];
		x = x ^ (x << SHIFT_A);
		y = s[3] ^ (s[3] >> SHIFT_A) ^ x;
		n[0] = s[1];
		n[1] = s[2] ^ (y[0] ? mat1 : '0);
		n[2] = x ^ (y << SHIFT_B) ^ (y[0] ? mat2 : '0);
		n[3] = y;
		return n;
	endfunction

	function automatic word_t temper(input state_t s, input word_t tmat);
		word_t t1;
		t1 = s[0] + (s[2] >> SHIFT_T);
		return s[3] ^ t1 ^ (t1[0] ? tmat : '0);
	endfunction

endpackage
`default_nettype wire

@@ design/tmt32_seq.sv @@
// Microcode sequencer: step counter, control store, loop counter and branch logic.
`default_nettype none
module tmt32_seq
	import tmt32_pkg::*;
#(
	parameter int MIX_ROUNDS   = 8,
	parameter int WARMUP_STEPS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic     req_oper,
	input  wire logic     out_busy,
	output logic          req_ready,
	output step_t         step,
	output dp_ctrl_t      ctrl
);

	localparam int CNT_MAX = (MIX_ROUNDS > WARMUP_STEPS) ? MIX_ROUNDS : WARMUP_STEPS;
	localparam int CNT_W   = ($clog2(CNT_MAX) < 2) ? 2 : $clog2(CNT_MAX);

	step_t            step_q;
	step_t            step_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	uword_t           uw;
	logic             held;
	logic             taken;
	logic             jump;

	assign uw        = urom(step_q);
	assign req_ready = (step_q == S_DISPATCH);
	assign taken     = req_valid && req_ready;
	assign held      = uw.hold_out && out_busy;
	assign step      = step_q;

	always_comb begin
		jump = 1'b0;
		unique case (uw.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_DISPATCH:  jump = (req_oper == OPER_GEN);
			C_NO_MIX:    jump = (MIX_ROUNDS == 1);
			C_MIX_MORE:  jump = (cnt_q != CNT_W'(MIX_ROUNDS - 1));
			C_NO_WARM:   jump = (WARMUP_STEPS == 0);
			C_WARM_MORE: jump = (cnt_q != CNT_W'(WARMUP_STEPS - 1));
			default:     jump = 1'b0;
		endcase
	end

	always_comb begin
		step_d = step_q;
		cnt_d  = cnt_q;
		if (held || (uw.cond == C_DISPATCH && !taken)) begin
			step_d = step_q;
		end else begin
			step_d = jump ? uw.target : step_q + step_t'(1);
			unique case (uw.op)
				OP_LOAD:                cnt_d = CNT_W'(1);
				OP_CERT:                cnt_d = '0;
				OP_MIX, OP_ADV:         cnt_d = cnt_q + CNT_W'(1);
				OP_NOP, OP_MUL, OP_GEN: cnt_d = cnt_q;
				default:                cnt_d = cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_DISPATCH;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			cnt_q  <= cnt_d;
		end
	end

	assign ctrl.op    = held ? OP_NOP : uw.op;
	assign ctrl.round = ROUND_W'(cnt_q);

endmodule
`default_nettype wire

@@ design/tmt32_dp.sv @@
// Datapath: parameter registers, state words, mixing multiplier and output register.
`default_nettype none
module tmt32_dp
	import tmt32_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire word_t    cfg_data,
	input  wire logic     seed_take,
	input  wire word_t    seed_in,
	input  wire dp_ctrl_t ctrl,
	input  wire logic     out_ready,
	output logic          out_valid,
	output word_t         out_word
);

	word_t  mat1_q;
	word_t  mat2_q;
	word_t  tmat_q;
	word_t  seed_q;
	state_t st_q;
	word_t  prod_q;
	word_t  out_q;
	logic   out_valid_q;
	state_t adv;
	word_t  mix_src;
	word_t  mix_in;
	logic [1:0] src_idx;
	logic [1:0] dst_idx;
	logic   all_zero;

	assign adv      = advance(st_q, mat1_q, mat2_q);
	assign src_idx  = 2'(ctrl.round - round_t'(1));
	assign dst_idx  = ctrl.round[1:0];
	assign mix_src  = st_q[src_idx];
	assign mix_in   = mix_src ^ (mix_src >> MIX_SHIFT);
	assign all_zero = ((st_q[0] & LOW31_MASK) == '0) && (st_q[1] == '0) &&
	                  (st_q[2] == '0) && (st_q[3] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat1_q <= MAT1_RESET;
			mat2_q <= MAT2_RESET;
			tmat_q <= TMAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAT1: mat1_q <= cfg_data;
				REG_MAT2: mat2_q <= cfg_data;
				REG_TMAT: tmat_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			unique case (ctrl.op)
				OP_LOAD: st_q <= {tmat_q, mat2_q, mat1_q, seed_q};
				OP_MIX:  st_q[dst_idx] <= st_q[dst_idx] ^ (prod_q + 32'(ctrl.round));
				OP_CERT: begin
					if (all_zero) begin
						st_q <= {CHAR_Y, CHAR_N, CHAR_I, CHAR_T};
					end
				end
				OP_ADV, OP_GEN:  st_q <= adv;
				OP_NOP, OP_MUL:  ;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seed_take) begin
			seed_q <= seed_in;
		end
		if (ctrl.op == OP_MUL) begin
			prod_q <= MIX_MULT * mix_in;
		end
		if (ctrl.op == OP_GEN) begin
			out_q <= temper(adv, tmat_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_GEN) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire

@@ design/tiny_mersenne_twister_32.sv @@
// Top level of the microcoded TinyMT32 pseudo-random generator.
//
//  Channel   Direction  Contents
//  s_*       in         tuser = operation (0 seed, 1 generate), tdata = seed word
//  m_*       out        tdata = tempered 32-bit random word
//  cfg_*     in         index 0 mat1, 1 mat2, 2 tmat; index 3 is ignored
//
// A generate request is dispatched and then advanced and tempered at the generate step.
// A seed request loads the state, mixes it in a loop of multiply and mix steps that
// share one multiplier, certifies it and runs WARMUP_STEPS warm-up state updates.
// Reset clears the state words to zero and loads the parameter defaults.
// A full output register that is not taken stalls the sequencer at its generate step.
`default_nettype none
`include "tiny_mersenne_twister_32_assert.svh"
module tiny_mersenne_twister_32
	import tmt32_pkg::*;
#(
	parameter int MIX_ROUNDS   = 8,
	parameter int WARMUP_STEPS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] seed_value
	input  wire logic        s_tuser,  // [0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] random_word
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	dp_ctrl_t ctrl;
	step_t    step;
	logic     out_busy;
	logic     taken;

	assign out_busy = m_tvalid && !m_tready;
	assign taken    = s_tvalid && s_tready;

	tmt32_seq #(
		.MIX_ROUNDS  (MIX_ROUNDS),
		.WARMUP_STEPS(WARMUP_STEPS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_oper (s_tuser),
		.out_busy (out_busy),
		.req_ready(s_tready),
		.step     (step),
		.ctrl     (ctrl)
	);

	tmt32_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.seed_take(taken),
		.seed_in  (s_tdata),
		.ctrl     (ctrl),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_word (m_tdata)
	);

	`TMT32_ASSERT_NEXT(a_gen_dispatch, clk, arst_n, taken && s_tuser == OPER_GEN,
		step == S_GEN, "Generate request did not reach the generate step.")
	`TMT32_ASSERT_NEXT(a_seed_dispatch, clk, arst_n, taken && s_tuser == OPER_SEED,
		step == S_LOAD, "Seed request did not reach the load step.")
	`TMT32_ASSERT_NEXT(a_gen_result, clk, arst_n, step == S_GEN && !out_busy,
		m_tvalid && step == S_DISPATCH, "Generate step gave no result.")
	`TMT32_ASSERT_NOW(a_busy_hold, clk, arst_n, step == S_GEN && out_busy,
		ctrl.op == OP_NOP, "Generate step ran while the output was full.")

endmodule
`default_nettype wire

@@ bench/tiny_mersenne_twister_32_test.sv @@
// Self-checking bench for the TinyMT32 generator with a predicting scoreboard and random stalls.
import tmt32_pkg::*;

localparam word_t KEEP_LOW31 = 32'h7fff_ffff;
localparam word_t MIX_FACTOR = 32'd1812433253;
localparam int MIX_COUNT = 8;
localparam int WARM_COUNT = 8;
localparam word_t TAG_T = "T";
localparam word_t TAG_I = "I";
localparam word_t TAG_N = "N";
localparam word_t TAG_Y = "Y";

function automatic word_t mix_term(input word_t p, input word_t rnd);
	return MIX_FACTOR * (p ^ (p >> 30)) + rnd;
endfunction

class rng_scoreboard;
	word_t mat1;
	word_t mat2;
	word_t tmat;
	word_t gen[4];
	word_t pending[$];
	int mismatches;

	function new();
		mat1 = MAT1_RESET;
		mat2 = MAT2_RESET;
		tmat = TMAT_RESET;
		gen = '{default: '0};
		mismatches = 0;
	endfunction

	task report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function void set_register(input logic [1:0] idx, input word_t value);
		case (idx)
			REG_MAT1: begin
				mat1 = value;
			end
			REG_MAT2: begin
				mat2 = value;
			end
			REG_TMAT: begin
				tmat = value;
			end
			default: begin
			end
		endcase
	endfunction

	function void step_state();
		word_t x;
		word_t y;
		word_t fb;
		x = (gen[0] & KEEP_LOW31) ^ gen[1] ^ gen[2];
		x = x ^ (x << 1);
		y = gen[3] ^ (gen[3] >> 1) ^ x;
		fb = {32{y[0]}};
		gen[0] = gen[1];
		gen[1] = gen[2] ^ (fb & mat1);
		gen[2] = x ^ (y << 10) ^ (fb & mat2);
		gen[3] = y;
	endfunction

	function word_t tempered_word();
		word_t t1;
		t1 = gen[0] + (gen[2] >> 8);
		return gen[3] ^ t1 ^ (t1[0] ? tmat : '0);
	endfunction

	function void load_seed(input word_t seed);
		gen = '{seed, mat1, mat2, tmat};
		for (int r = 1; r < MIX_COUNT; r++) begin
			gen[r % 4] = gen[r % 4] ^ mix_term(gen[(r - 1) % 4], word_t'(r));
		end
		if ((gen[0] & KEEP_LOW31) == '0 && gen[1] == '0 && gen[2] == '0 && gen[3] == '0) begin
			gen = '{TAG_T, TAG_I, TAG_N, TAG_Y};
		end
		repeat (WARM_COUNT) step_state();
	endfunction

	function void note_request(input logic op, input word_t value);
		if (op == OPER_SEED) begin
			load_seed(value);
		end else begin
			step_state();
			pending.push_back(tempered_word());
		end
	endfunction

	task check_word(input word_t got);
		word_t want;
		if (pending.size() == 0) begin
			report_mismatch($sformatf("unexpected word %h", got));
		end else begin
			want = pending.pop_front();
			if (got !== want) begin
				report_mismatch($sformatf("random_word %h, expected %h", got, want));
			end
		end
	endtask
endclass

module tiny_mersenne_twister_32_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 250;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum {SET_DEFAULT, SET_ZERO, SET_ONES, SET_RANDOM, SET_ZEROING} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = OPER_GEN;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	bit quiet = 1'b0;
	rng_scoreboard sb;

	always #5 clk = ~clk;

	tiny_mersenne_twister_32 dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_word(m_tdata);
		end
		m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic send_request(input logic op, input word_t value);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(op, value);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_parameters(input word_t m1, input word_t m2, input word_t tm);
		logic [1:0] regs [4];
		word_t vals [4];
		regs = '{REG_MAT1, REG_MAT2, REG_TMAT, REG_SPARE};
		vals = '{m1, m2, tm, $urandom};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_register(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// The parameters and seed are worked back from the last mixing round so that the
	// mixed state is zero but for bit 31 of word 0 and the generator must fall back on its fixed words.
	task automatic zeroing_case(input word_t top);
		word_t a;
		word_t b;
		word_t c;
		word_t seed;
		a = mix_term('0, 7);
		b = mix_term('0, 6);
		c = mix_term(top, 5);
		seed = top ^ mix_term(a, 4);
		set_parameters(c ^ mix_term(seed, 1), b ^ mix_term(c, 2), a ^ mix_term(b, 3));
		send_request(OPER_SEED, seed);
	endtask

	task automatic apply_setting(input setting_t kind);
		case (kind)
			SET_DEFAULT: begin
				set_parameters(MAT1_RESET, MAT2_RESET, TMAT_RESET);
			end
			SET_ZERO: begin
				set_parameters('0, '0, '0);
			end
			SET_ONES: begin
				set_parameters('1, '1, '1);
			end
			SET_RANDOM: begin
				set_parameters($urandom, $urandom, $urandom);
			end
			default: begin
				zeroing_case($urandom_range(1) ? 32'h8000_0000 : 32'h0000_0000);
			end
		endcase
	endtask

	function automatic word_t pick_seed();
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'hffff_ffff;
				2: return 32'h8000_0000;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request(OPER_GEN, '1);
		send_request(OPER_GEN, '0);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_SEED, '0);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_SEED, '1);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_SEED, 32'h8000_0000);
		send_request(OPER_SEED, 32'h0000_0001);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_GEN, $urandom);
		drain();
		apply_setting(SET_ZERO);
		send_request(OPER_SEED, $urandom);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_GEN, $urandom);
		drain();
		apply_setting(SET_ONES);
		send_request(OPER_SEED, $urandom);
		send_request(OPER_GEN, $urandom);
		drain();
		zeroing_case(32'h0000_0000);
		send_request(OPER_GEN, $urandom);
		send_request(OPER_GEN, $urandom);
		drain();
		zeroing_case(32'h8000_0000);
		send_request(OPER_GEN, $urandom);
		for (int p = 0; p < PHASES; p++) begin
			drain();
			quiet = (p == 2);
			apply_setting(p <= SET_ZEROING ? setting_t'(p) : setting_t'($urandom_range(SET_ZEROING)));
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(99) < 6) begin
					send_request(OPER_SEED, pick_seed());
				end else begin
					send_request(OPER_GEN, $urandom);
				end
			end
		end
		quiet = 1'b0;
		drain();
		if (sb.pending.size() != 0) begin
			sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending.size()));
		end
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
